@@ rtl/fcp_pkg.sv @@
package fcp_pkg;

    localparam int NUM_WORDS = 6;
    localparam int WORD_MAX  = 9;

    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_STOP      = 3'd1;
    localparam logic [2:0] CMD_CALIBRATE = 3'd2;
    localparam logic [2:0] CMD_LEFT      = 3'd3;
    localparam logic [2:0] CMD_RIGHT     = 3'd4;
    localparam logic [2:0] CMD_MOVE_TO   = 3'd5;
    localparam logic [2:0] CMD_STATUS    = 3'd6;

    localparam logic [7:0] CH_START = 8'h3E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_END   = 8'h21;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [WORD_MAX*8-1:0] t_word_text;

    localparam t_word_text WORD_TEXT [NUM_WORDS] = '{
        t_word_text'("stop"),
        t_word_text'("calibrate"),
        t_word_text'("left"),
        t_word_text'("right"),
        t_word_text'("move-to"),
        t_word_text'("status")
    };

    localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{4'd4, 4'd9, 4'd4, 4'd5, 4'd7, 4'd6};

    localparam logic [2:0] WORD_CODE [NUM_WORDS] = '{
        CMD_STOP, CMD_CALIBRATE, CMD_LEFT, CMD_RIGHT, CMD_MOVE_TO, CMD_STATUS
    };

    // character idx of word k, counted from the first character
    function automatic logic [7:0] word_char(input int k, input logic [3:0] idx);
        t_word_text w;
        int         pos;
        w   = WORD_TEXT[k];
        pos = int'(WORD_LEN[k]) - 1 - int'(idx);
        if (pos < 0) begin
            return 8'h00;
        end
        return w[pos*8 +: 8];
    endfunction

endpackage

@@ rtl/framed_command_parser.sv @@
// An accepted '!' byte that ends a frame is registered into the result shown on o_res_valid.
// Throughput: one rx byte per cycle while o_rx_stall is low; the result register frees in the cycle it is taken.
// o_rx_stall is high only while a result is held and i_res_stall is high.
// Name matching compares each name byte against all six constant command words in parallel.
// Reset (i_rst_n low, synchronous): idle outside any frame, no result pending.
module framed_command_parser #(
    parameter int NAME_CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [2:0]  o_command_code,
    output logic signed [31:0] o_argument
);
    import fcp_pkg::*;

    localparam int LEN_W = $clog2(NAME_CAPACITY + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_NAME,
        PH_ARG
    } t_frame_phase;

    typedef enum logic [1:0] {
        NUM_WS,
        NUM_DIGITS,
        NUM_DONE
    } t_num_phase;

    t_frame_phase           r_phase, n_phase;
    t_num_phase             r_num, n_num;
    logic [LEN_W-1:0]       r_name_len, n_name_len;
    logic                   r_overflow, n_overflow;
    logic [NUM_WORDS-1:0]   r_match, n_match;
    logic                   r_neg, n_neg;
    logic [31:0]            r_mag, n_mag;
    logic                   r_res_valid, n_res_valid;
    logic [2:0]             r_code, n_code;
    logic [31:0]            r_arg, n_arg;

    logic                   accept;
    logic                   is_digit;
    logic                   is_space;
    logic [31:0]            digit_val;
    logic [NUM_WORDS-1:0]   hit;
    logic [2:0]             found_code;

    assign o_rx_stall     = r_res_valid & i_res_stall;
    assign accept         = i_rx_valid & ~o_rx_stall;
    assign o_res_valid    = r_res_valid;
    assign o_command_code = r_code;
    assign o_argument     = r_arg;

    assign is_digit  = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign is_space  = i_rx_byte inside {[CH_TAB:CH_CR], CH_SPACE};
    assign digit_val = {24'd0, i_rx_byte - CH_ZERO};

    always_comb begin
        found_code = CMD_NONE;
        for (int k = 0; k < NUM_WORDS; k++) begin
            hit[k] = r_match[k] && (r_name_len == LEN_W'(WORD_LEN[k]));
            if (hit[k]) begin
                found_code = WORD_CODE[k];
            end
        end
        if (r_overflow || r_name_len == '0) begin
            found_code = CMD_NONE;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_num       = r_num;
        n_name_len  = r_name_len;
        n_overflow  = r_overflow;
        n_match     = r_match;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_res_valid = r_res_valid & i_res_stall;
        n_code      = r_code;
        n_arg       = r_arg;
        if (accept) begin
            if (i_rx_byte == CH_START) begin
                n_phase    = PH_NAME;
                n_name_len = '0;
                n_overflow = 1'b0;
                n_match    = '1;
                n_num      = NUM_WS;
                n_neg      = 1'b0;
                n_mag      = '0;
            end else if (r_phase != PH_IDLE) begin
                if (i_rx_byte == CH_COLON) begin
                    n_phase = PH_ARG;
                    n_num   = NUM_WS;
                    n_neg   = 1'b0;
                    n_mag   = '0;
                end else if (i_rx_byte == CH_END) begin
                    n_phase     = PH_IDLE;
                    n_res_valid = 1'b1;
                    n_code      = found_code;
                    n_arg       = '0;
                    if (found_code == CMD_MOVE_TO) begin
                        n_arg = r_neg ? (32'd0 - r_mag) : r_mag;
                    end
                end else if (r_phase == PH_NAME) begin
                    if (r_name_len < LEN_W'(NAME_CAPACITY)) begin
                        for (int k = 0; k < NUM_WORDS; k++) begin
                            n_match[k] = r_match[k]
                                && (r_name_len < LEN_W'(WORD_LEN[k]))
                                && (i_rx_byte == word_char(k, r_name_len[3:0]));
                        end
                        n_name_len = r_name_len + LEN_W'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                end else begin
                    case (r_num)
                        NUM_WS: begin
                            if (!is_space) begin
                                n_num = NUM_DIGITS;
                                if (i_rx_byte == CH_MINUS) begin
                                    n_neg = 1'b1;
                                end else if (is_digit) begin
                                    n_mag = digit_val;
                                end else if (i_rx_byte != CH_PLUS) begin
                                    n_num = NUM_DONE;
                                end
                            end
                        end
                        NUM_DIGITS: begin
                            if (is_digit) begin
                                n_mag = (r_mag << 3) + (r_mag << 1) + digit_val;
                            end else begin
                                n_num = NUM_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_num       <= NUM_WS;
            r_name_len  <= '0;
            r_overflow  <= 1'b0;
            r_match     <= '0;
            r_neg       <= 1'b0;
            r_mag       <= '0;
            r_res_valid <= 1'b0;
            r_code      <= CMD_NONE;
            r_arg       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_num       <= n_num;
            r_name_len  <= n_name_len;
            r_overflow  <= n_overflow;
            r_match     <= n_match;
            r_neg       <= n_neg;
            r_mag       <= n_mag;
            r_res_valid <= n_res_valid;
            r_code      <= n_code;
            r_arg       <= n_arg;
        end
    end

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit))
        else $error("more than one command word matches");

    a_arg_only_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && (r_code != CMD_MOVE_TO) |-> r_arg == '0)
        else $error("argument reported for a command other than move-to");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_name_len <= LEN_W'(NAME_CAPACITY))
        else $error("name length beyond capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> r_name_len == LEN_W'(NAME_CAPACITY))
        else $error("overflow flagged with room left");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_rx_byte == CH_END) && (r_phase != PH_IDLE)
        |=> r_res_valid && (r_phase == PH_IDLE))
        else $error("frame end produced no result");

endmodule

@@ tb/framed_command_parser_checker.sv @@
`timescale 1ns / 100ps

module framed_command_parser_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    input  logic               i_rx_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic [2:0]         i_command_code,
    input  logic signed [31:0] i_argument,
    output int                 o_mismatches,
    output int                 o_pending
);
    import fcp_pkg::*;

    localparam int NAME_CAP = 16;

    typedef enum logic [1:0] {FRAME_IDLE, FRAME_NAME, FRAME_ARG} t_frame_phase;
    typedef enum logic [1:0] {NUM_SKIP_WS, NUM_DIGITS, NUM_DONE} t_number_phase;

    typedef struct packed {
        logic [2:0]  code;
        logic [31:0] arg;
    } t_parsed_cmd;

    string            cmd_words [6] = '{"stop", "calibrate", "left", "right", "move-to", "status"};
    localparam logic [2:0] CMD_OF_WORD [6] = '{
        CMD_STOP, CMD_CALIBRATE, CMD_LEFT, CMD_RIGHT, CMD_MOVE_TO, CMD_STATUS
    };

    t_frame_phase     frame = FRAME_IDLE;
    logic [7:0]       name_buf [NAME_CAP];
    int               name_len = 0;
    logic             name_too_long = 1'b0;
    t_number_phase    num_phase = NUM_SKIP_WS;
    logic             num_neg = 1'b0;
    logic [31:0]      num_mag = '0;

    t_parsed_cmd      expected_cmds [$];
    int               mismatch_total = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    task automatic restart_number();
        num_phase = NUM_SKIP_WS;
        num_neg   = 1'b0;
        num_mag   = '0;
    endtask

    function automatic logic [2:0] match_name();
        logic hit;
        if (name_too_long || name_len == 0) begin
            return CMD_NONE;
        end
        for (int k = 0; k < 6; k++) begin
            if (cmd_words[k].len() == name_len) begin
                hit = 1'b1;
                for (int i = 0; i < name_len; i++) begin
                    if (name_buf[i] != cmd_words[k][i]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    return CMD_OF_WORD[k];
                end
            end
        end
        return CMD_NONE;
    endfunction

    // atoi-style: whitespace, optional sign, digits; anything else ends it
    task automatic take_number_byte(input logic [7:0] b);
        logic is_digit;
        is_digit = (b >= CH_ZERO && b <= CH_NINE);
        if (num_phase == NUM_SKIP_WS) begin
            if (b == CH_PLUS) begin
                num_phase = NUM_DIGITS;
            end else if (b == CH_MINUS) begin
                num_neg   = 1'b1;
                num_phase = NUM_DIGITS;
            end else if (is_digit) begin
                num_mag   = 32'(b - CH_ZERO);
                num_phase = NUM_DIGITS;
            end else if (!(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
                num_phase = NUM_DONE;
            end
        end else if (num_phase == NUM_DIGITS) begin
            if (is_digit) begin
                num_mag = num_mag * 32'd10 + 32'(b - CH_ZERO);
            end else begin
                num_phase = NUM_DONE;
            end
        end
    endtask

    task automatic track_rx_byte(input logic [7:0] b);
        t_parsed_cmd done;
        if (b == CH_START) begin
            frame         = FRAME_NAME;
            name_len      = 0;
            name_too_long = 1'b0;
            restart_number();
        end else if (frame != FRAME_IDLE) begin
            if (b == CH_COLON) begin
                frame = FRAME_ARG;
                restart_number();
            end else if (b == CH_END) begin
                done.code = match_name();
                done.arg  = '0;
                if (done.code == CMD_MOVE_TO) begin
                    done.arg = num_neg ? (32'd0 - num_mag) : num_mag;
                end
                expected_cmds.push_back(done);
                frame = FRAME_IDLE;
            end else if (frame == FRAME_NAME) begin
                if (name_len < NAME_CAP) begin
                    name_buf[name_len] = b;
                    name_len++;
                end else begin
                    name_too_long = 1'b1;
                end
            end else begin
                take_number_byte(b);
            end
        end
    endtask

    task automatic check_result();
        t_parsed_cmd want;
        if (expected_cmds.size() == 0) begin
            report_mismatch($sformatf("unexpected result code %0d arg %0d",
                                      i_command_code, i_argument));
            return;
        end
        want = expected_cmds.pop_front();
        if (i_command_code !== want.code) begin
            report_mismatch($sformatf("command_code %0d, want %0d", i_command_code, want.code));
        end
        if (i_argument !== want.arg) begin
            report_mismatch($sformatf("argument %0d, want %0d",
                                      i_argument, $signed(want.arg)));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_res_valid && !i_res_stall) begin
                check_result();
            end
            if (i_rx_valid && !i_rx_stall) begin
                track_rx_byte(i_rx_byte);
            end
        end
        o_pending    <= expected_cmds.size();
        o_mismatches <= mismatch_total;
    end

endmodule

@@ tb/framed_command_parser_tb.sv @@
`timescale 1ns / 100ps

module framed_command_parser_tb;
    import fcp_pkg::*;

    localparam int TOTAL_BYTES = 1250;
    localparam int TAIL_START  = 1100;
    localparam int PAUSE_AT    = 650;

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               rx_valid = 1'b0;
    logic [7:0]         rx_byte = '0;
    logic               res_stall = 1'b0;
    logic               o_rx_stall;
    logic               o_res_valid;
    logic [2:0]         o_command_code;
    logic signed [31:0] o_argument;

    int                 mismatch_count;
    int                 pending_results;

    logic [7:0]         frame_q [$];
    string              word_list [6] = '{"stop", "calibrate", "left", "right", "move-to", "status"};
    int                 sent_bytes = 0;
    logic               gaps_on = 1'b1;
    logic               tail_phase = 1'b0;

    always #5 i_clk = ~i_clk;

    framed_command_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (res_stall),
        .o_command_code (o_command_code),
        .o_argument     (o_argument)
    );

    framed_command_parser_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .i_rx_stall     (o_rx_stall),
        .i_rx_byte      (rx_byte),
        .i_res_valid    (o_res_valid),
        .i_res_stall    (res_stall),
        .i_command_code (o_command_code),
        .i_argument     (o_argument),
        .o_mismatches   (mismatch_count),
        .o_pending      (pending_results)
    );

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CH_START) ? CH_END : b;
    endfunction

    // any byte that is not a frame delimiter
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_START || b == CH_COLON || b == CH_END) begin
            b = 8'h78;
        end
        return b;
    endfunction

    function automatic logic [7:0] space_byte();
        int r;
        r = $urandom_range(9, 14);
        return (r == 14) ? CH_SPACE : 8'(r);
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            frame_q.push_back(s[i]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (gaps_on && !tail_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_queued();
        foreach (frame_q[i]) begin
            send_byte(frame_q[i]);
        end
        frame_q = {};
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_queued();
    endtask

    task automatic wait_all_results();
        rx_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    task automatic push_argument();
        int digits;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(0, 5)) frame_q.push_back(plain_byte());
            return;
        end
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) frame_q.push_back(space_byte());
        end
        case ($urandom_range(0, 3))
            0: frame_q.push_back(CH_PLUS);
            1: frame_q.push_back(CH_MINUS);
            default: ;
        endcase
        digits = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 14) : $urandom_range(1, 10);
        repeat (digits) frame_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) frame_q.push_back(plain_byte());
        end
    endtask

    task automatic send_random_frame();
        int    kind;
        int    pick;
        int    n;
        string w;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) frame_q.push_back(noise_byte());
        end
        frame_q.push_back(CH_START);
        kind = $urandom_range(0, 11);
        if (kind < 8) begin
            pick = $urandom_range(0, 9);
            if (pick > 5) begin
                pick = 4;
            end
            w = word_list[pick];
            if ($urandom_range(0, 7) == 0) begin
                w[$urandom_range(0, w.len() - 1)] = plain_byte();
            end
            push_text(w);
        end else if (kind == 9) begin
            repeat ($urandom_range(15, 20)) frame_q.push_back(plain_byte());
        end else if (kind > 9) begin
            repeat ($urandom_range(1, 12)) frame_q.push_back(plain_byte());
        end
        n = $urandom_range(0, 9);
        if (n != 0) begin
            if (n == 1) begin
                frame_q.push_back(CH_COLON);
                push_argument();
            end
            frame_q.push_back(CH_COLON);
            push_argument();
        end
        // mostly closed frames; some left open, some followed by a stray end
        n = $urandom_range(0, 19);
        if (n != 0) begin
            frame_q.push_back(CH_END);
        end
        if (n == 1) begin
            frame_q.push_back(CH_END);
        end
        send_queued();
    endtask

    initial begin
        int n;
        forever begin
            n = $urandom_range(1, 12);
            res_stall <= !tail_phase && ($urandom_range(0, 2) == 0);
            repeat (n) @(posedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("q!>stop!");
        send_text(">calibrate!");
        send_text(">left:5!");
        send_text(">right!");
        send_text(">status!");
        send_text(">move-to: \t-2147483648!");
        send_text(">move-to:+4294967295x9!");
        send_text(">move-to:2147483647!");
        send_text(">move-to:1:-2!");
        send_text(">move-to!");
        send_text(">!");
        send_text(">abcdefghijklmnopq!");
        send_text(">sto>stop:7!");
        frame_q.push_back(8'hFF);
        push_text(">stop");
        frame_q.push_back(8'h00);
        frame_q.push_back(CH_END);
        send_queued();
        wait_all_results();

        while (sent_bytes < TOTAL_BYTES) begin
            gaps_on = ($urandom_range(0, 9) > 2);
            if (sent_bytes >= TAIL_START) begin
                tail_phase = 1'b1;
            end
            if (sent_bytes >= PAUSE_AT && sent_bytes < PAUSE_AT + 40) begin
                wait_all_results();
            end
            send_random_frame();
        end

        wait_all_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
